// ----- rtl/gtop_pkg.sv -----
// Shared types, constants and the arctangent table for the go-to-origin controller.
// No dependencies; gtop_pipe and the controller core import this package.
`timescale 1ns / 1ps
package gtop_pkg;

  // Number of CORDIC rotation steps (valid range 8 to 24).
  localparam int CORDIC_STEPS = 16;
  // The integer square root of a 32-bit sum yields one result bit per step.
  localparam int ISQRT_STEPS  = 16;
  localparam int PIPE_DEPTH   = (CORDIC_STEPS > ISQRT_STEPS) ? CORDIC_STEPS : ISQRT_STEPS;

  // Angle constants in Q2.30.
  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [35:0] PI_NINTH    = 36'sd374806603;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_ARRIVE_DIST = 3'd0,
    CFG_DIST_GAIN   = 3'd1,
    CFG_HEAD_GAIN   = 3'd2,
    CFG_LIN_LIMIT   = 3'd3,
    CFG_ANG_LIMIT   = 3'd4
  } cfg_idx_t;

  // One word in flight through the square-root / CORDIC pipeline.
  typedef struct packed {
    logic               valid;
    logic               zero;
    logic signed [35:0] x;
    logic signed [35:0] y;
    logic signed [35:0] z;
    logic        [17:0] rem;
    logic        [15:0] root;
    logic        [31:0] rad;
    logic signed [15:0] theta;
  } gtop_stage_t;

  // arctan(2^-i) in Q2.30.
  function automatic logic signed [35:0] atan_q30(input int i);
    logic signed [35:0] a;
    begin
      unique case (i)
        0: a = 36'sd843314856;   1: a = 36'sd497837829;
        2: a = 36'sd263043836;   3: a = 36'sd133525158;
        4: a = 36'sd67021686;    5: a = 36'sd33543515;
        6: a = 36'sd16775850;    7: a = 36'sd8388437;
        8: a = 36'sd4194282;     9: a = 36'sd2097149;
        10: a = 36'sd1048575;    11: a = 36'sd524287;
        12: a = 36'sd262143;     13: a = 36'sd131071;
        14: a = 36'sd65535;      15: a = 36'sd32767;
        16: a = 36'sd16383;      17: a = 36'sd8191;
        18: a = 36'sd4095;       19: a = 36'sd2047;
        20: a = 36'sd1023;       21: a = 36'sd511;
        22: a = 36'sd255;        23: a = 36'sd127;
        default: a = '0;
      endcase
      return a;
    end
  endfunction

endpackage

// ----- rtl/gtop_if.sv -----
// Valid/ready channel interfaces for pose words and command words.
// Depends on nothing.
`timescale 1ns / 1ps
interface gtop_pose_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pose_x;
  logic signed [15:0] pose_y;
  logic signed [15:0] pose_heading;

  modport source (output valid, pose_x, pose_y, pose_heading, input ready);
  modport sink (input valid, pose_x, pose_y, pose_heading, output ready);
endinterface

interface gtop_cmd_if;
  logic               valid;
  logic               ready;
  logic               arrived;
  logic        [14:0] linear_cmd;
  logic signed [15:0] angular_cmd;

  modport source (output valid, arrived, linear_cmd, angular_cmd, input ready);
  modport sink (input valid, arrived, linear_cmd, angular_cmd, output ready);
endinterface

// ----- rtl/gtop_pipe.sv -----
// Iterative pipeline: one square-root bit and one CORDIC vectoring step per stage.
// Depends on gtop_pkg.
`timescale 1ns / 1ps
module gtop_pipe import gtop_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  gtop_stage_t in_stage,
  output gtop_stage_t out_stage
);

  gtop_stage_t st_in [PIPE_DEPTH];
  gtop_stage_t st_nxt [PIPE_DEPTH];
  gtop_stage_t st_r [PIPE_DEPTH];

  assign out_stage = st_r[PIPE_DEPTH-1];

  for (genvar i = 0; i < PIPE_DEPTH; i++) begin : g_stage
    // Stage i works on the pipeline input or on the register of the stage before it.
    if (i == 0) begin : g_head
      assign st_in[i] = in_stage;
    end else begin : g_link
      assign st_in[i] = st_r[i-1];
    end

    // Combinational work of stage i.
    always_comb begin
      logic [17:0] rem_sh;
      logic [17:0] trial;
      logic signed [35:0] xs;
      logic signed [35:0] ys;
      st_nxt[i] = st_in[i];
      rem_sh = {st_in[i].rem[15:0], st_in[i].rad[31:30]};
      trial  = {st_in[i].root, 2'b01};
      xs = st_in[i].x >>> i;
      ys = st_in[i].y >>> i;
      if (i < ISQRT_STEPS) begin
        st_nxt[i].rad = {st_in[i].rad[29:0], 2'b00};
        if (rem_sh >= trial) begin
          st_nxt[i].rem  = rem_sh - trial;
          st_nxt[i].root = {st_in[i].root[14:0], 1'b1};
        end else begin
          st_nxt[i].rem  = rem_sh;
          st_nxt[i].root = {st_in[i].root[14:0], 1'b0};
        end
      end
      if (i < CORDIC_STEPS) begin
        if (st_in[i].y > 0) begin
          st_nxt[i].x = st_in[i].x + ys;
          st_nxt[i].y = st_in[i].y - xs;
          st_nxt[i].z = st_in[i].z + atan_q30(i);
        end else begin
          st_nxt[i].x = st_in[i].x - ys;
          st_nxt[i].y = st_in[i].y + xs;
          st_nxt[i].z = st_in[i].z - atan_q30(i);
        end
      end
    end

    // Stage register; the valid bit is the only reset state.
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[i].valid <= 1'b0;
      end else if (adv) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

endmodule

// ----- rtl/go_to_origin_pose_controller_core.sv -----
// Go-to-origin unicycle controller top level: config registers, pre/post stages.
// Depends on gtop_pkg, gtop_if and gtop_pipe.
`timescale 1ns / 1ps
// The controller takes one pose word per clock while the output word is not stalled
// and returns one command word per pose, in order, through stages A and B, the
// square-root and CORDIC iteration stages, one step each, and stages C to F.
// The whole pipeline holds when the output word is not taken, so in_word.ready
// follows out_word.ready. The user must write configuration only while no pose
// is in flight; the block itself does not enforce this.
module go_to_origin_pose_controller_core import gtop_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  gtop_pose_if.sink   in_word,
  gtop_cmd_if.source  out_word,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] arrive_dist_r;
  logic [15:0] dist_gain_r;
  logic [15:0] head_gain_r;
  logic [14:0] lin_limit_r;
  logic [14:0] ang_limit_r;
  logic        adv;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arrive_dist_r <= 16'd26;
      dist_gain_r   <= 16'd4096;
      head_gain_r   <= 16'd4096;
      lin_limit_r   <= 15'd256;
      ang_limit_r   <= 15'd8192;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ARRIVE_DIST: arrive_dist_r <= cfg_data;
        CFG_DIST_GAIN:   dist_gain_r   <= cfg_data;
        CFG_HEAD_GAIN:   head_gain_r   <= cfg_data;
        CFG_LIN_LIMIT:   lin_limit_r   <= cfg_data[14:0];
        CFG_ANG_LIMIT:   ang_limit_r   <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves as a whole unless the output word is stalled.
  logic out_valid_r;
  assign adv = !out_valid_r || out_word.ready;
  assign in_word.ready = adv;

  // Stage A: negate the pose to get the vector toward the origin.
  logic               a_valid_r;
  logic signed [16:0] a_dx_r;
  logic signed [16:0] a_dy_r;
  logic signed [15:0] a_theta_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= in_word.valid;
      a_dx_r    <= -{in_word.pose_x[15], in_word.pose_x};
      a_dy_r    <= -{in_word.pose_y[15], in_word.pose_y};
      a_theta_r <= in_word.pose_heading;
    end
  end

  // Stage B: squared radius and the quadrant pre-rotation of the CORDIC.
  gtop_stage_t b_nxt;
  gtop_stage_t b_r;

  always_comb begin
    logic signed [33:0] sqx;
    logic signed [33:0] sqy;
    logic signed [35:0] xi;
    logic signed [35:0] yi;
    sqx = a_dx_r * a_dx_r;
    sqy = a_dy_r * a_dy_r;
    xi  = {{3{a_dx_r[16]}}, a_dx_r, 16'd0};
    yi  = {{3{a_dy_r[16]}}, a_dy_r, 16'd0};
    b_nxt.valid = a_valid_r;
    b_nxt.zero  = (a_dx_r == '0) && (a_dy_r == '0);
    b_nxt.rem   = '0;
    b_nxt.root  = '0;
    b_nxt.rad   = sqx[31:0] + sqy[31:0];
    b_nxt.theta = a_theta_r;
    b_nxt.x = xi;
    b_nxt.y = yi;
    b_nxt.z = '0;
    if (xi < 0) begin
      if (yi >= 0) begin
        b_nxt.x = yi;
        b_nxt.y = -xi;
        b_nxt.z = HALF_PI_Q30;
      end else begin
        b_nxt.x = -yi;
        b_nxt.y = xi;
        b_nxt.z = -HALF_PI_Q30;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r.valid <= 1'b0;
    end else if (adv) begin
      b_r <= b_nxt;
    end
  end

  gtop_stage_t p_out;

  gtop_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_stage  (b_r),
    .out_stage (p_out)
  );

  // Stage C: heading error before wrapping.
  logic               c_valid_r;
  logic [15:0]        c_r_r;
  logic signed [35:0] c_alpha_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (adv) begin
      c_valid_r <= p_out.valid;
      c_r_r     <= p_out.root;
      c_alpha_r <= (p_out.zero ? 36'sd0 : p_out.z)
                   - {{3{p_out.theta[15]}}, p_out.theta, 17'd0};
    end
  end

  // Stage D: wrap the heading error into minus pi to pi (two passes).
  logic               d_valid_r;
  logic [15:0]        d_r_r;
  logic signed [35:0] d_alpha_r;

  logic signed [35:0] w1;
  logic signed [35:0] w2;

  always_comb begin
    if (c_alpha_r > PI_Q30) begin
      w1 = c_alpha_r - TWO_PI_Q30;
    end else if (c_alpha_r < -PI_Q30) begin
      w1 = c_alpha_r + TWO_PI_Q30;
    end else begin
      w1 = c_alpha_r;
    end
    if (w1 > PI_Q30) begin
      w2 = w1 - TWO_PI_Q30;
    end else if (w1 < -PI_Q30) begin
      w2 = w1 + TWO_PI_Q30;
    end else begin
      w2 = w1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (adv) begin
      d_valid_r <= c_valid_r;
      d_r_r     <= c_r_r;
      d_alpha_r <= w2;
    end
  end

  // Stage E: gain products and the mode decisions.
  logic               e_valid_r;
  logic               e_arrived_r;
  logic               e_turn_r;
  logic               e_pos_r;
  logic [31:0]        e_lin_r;
  logic signed [50:0] e_rot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
    end else if (adv) begin
      e_valid_r   <= d_valid_r;
      e_arrived_r <= d_r_r < arrive_dist_r;
      e_turn_r    <= (d_alpha_r > PI_NINTH) || (d_alpha_r < -PI_NINTH);
      e_pos_r     <= d_alpha_r > 0;
      e_lin_r     <= dist_gain_r * d_r_r;
      e_rot_r     <= $signed({1'b0, head_gain_r}) * $signed(d_alpha_r[33:0]);
    end
  end

  // Stage F: rounding, saturation and the output word register.
  logic               arrived_nxt;
  logic [14:0]        lin_nxt;
  logic signed [15:0] ang_nxt;
  logic               arrived_r;
  logic [14:0]        lin_r;
  logic signed [15:0] ang_r;

  always_comb begin
    logic [32:0]        lsum;
    logic [20:0]        lv;
    logic signed [50:0] rsum;
    logic signed [21:0] rv;
    logic signed [21:0] lim;
    logic signed [15:0] lim16;
    lsum  = {1'b0, e_lin_r} + 33'd2048;
    lv    = lsum[32:12];
    rsum  = e_rot_r + 51'sd268435456;
    rv    = rsum[50:29];
    lim   = {7'd0, ang_limit_r};
    lim16 = {1'b0, ang_limit_r};
    arrived_nxt = e_arrived_r;
    lin_nxt = '0;
    ang_nxt = '0;
    if (e_arrived_r) begin
      lin_nxt = '0;
      ang_nxt = '0;
    end else if (e_turn_r) begin
      ang_nxt = e_pos_r ? lim16 : -lim16;
    end else begin
      lin_nxt = (lv > {6'd0, lin_limit_r}) ? lin_limit_r : lv[14:0];
      if (rv > lim) begin
        ang_nxt = lim16;
      end else if (rv < -lim) begin
        ang_nxt = -lim16;
      end else begin
        ang_nxt = rv[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= e_valid_r;
      arrived_r   <= arrived_nxt;
      lin_r       <= lin_nxt;
      ang_r       <= ang_nxt;
    end
  end

  assign out_word.valid       = out_valid_r;
  assign out_word.arrived     = arrived_r;
  assign out_word.linear_cmd  = lin_r;
  assign out_word.angular_cmd = ang_r;

endmodule

// ----- sim/tb_go_to_origin_pose_controller_core.sv -----
// Self-checking testbench for the go-to-origin pose controller core.
// Drives pose words with random gaps and back-pressure and checks each command word.
// Depends on rtl/gtop_pkg.sv, rtl/gtop_if.sv and the controller RTL.
`timescale 1ns / 1ps
module tb_go_to_origin_pose_controller_core;
  import gtop_pkg::*;

  localparam int          DRAIN_CYCLES = PIPE_DEPTH + 12;
  localparam int          CYCLE_LIMIT  = 1000000;
  localparam logic [2:0]  CFG_SPARE    = 3'd7;
  localparam longint      PI_L         = 64'sd3373259426;
  localparam longint      TWO_PI_L     = 64'sd6746518852;
  localparam longint      PI_NINTH_L   = 64'sd374806603;
  localparam longint      HALF_PI_L    = 64'sd1686629713;

  typedef struct {
    logic               arrived;
    logic        [14:0] linear_cmd;
    logic signed [15:0] angular_cmd;
  } cmd_word_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] heading;
  } pose_word_t;

  // arctan(2^-i) in Q2.30 for the bearing estimate.
  longint atan_steps [24] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
    65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  gtop_pose_if pose_ch ();
  gtop_cmd_if  cmd_ch ();

  go_to_origin_pose_controller_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (pose_ch),
    .out_word (cmd_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  // Local copy of the controller settings.
  logic [15:0] arrive_dist = 16'd26;
  logic [15:0] dist_gain   = 16'd4096;
  logic [15:0] head_gain   = 16'd4096;
  logic [14:0] lin_limit   = 15'd256;
  logic [14:0] ang_limit   = 15'd8192;

  pose_word_t pending_poses [$];
  cmd_word_t  expected_cmds [$];
  int  fail_count = 0;
  int  cycle_count = 0;
  bit  pose_taken = 1'b0;
  bit  no_idle = 1'b0;
  int  send_gap = 0;
  int  stall_left = 0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Vectoring CORDIC bearing of (dx, dy) in Q2.30.
  function automatic longint bearing_q30(longint dx, longint dy);
    longint vx, vy, ang, sx, sy, t;
    vx = dx * 65536;
    vy = dy * 65536;
    ang = 0;
    if (dx == 0 && dy == 0) return 0;
    if (vx < 0) begin
      t = vx;
      if (vy >= 0) begin
        vx = vy; vy = -t; ang = HALF_PI_L;
      end else begin
        vx = -vy; vy = t; ang = -HALF_PI_L;
      end
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      sx = vx >>> i;
      sy = vy >>> i;
      if (vy > 0) begin
        vx = vx + sy; vy = vy - sx; ang = ang + atan_steps[i];
      end else begin
        vx = vx - sy; vy = vy + sx; ang = ang - atan_steps[i];
      end
    end
    return ang;
  endfunction

  // Works out the command word for one pose under the current settings.
  function automatic cmd_word_t steer_to_origin(pose_word_t p);
    cmd_word_t c;
    longint dx, dy, alpha, turn, lim;
    longint unsigned radius, speed;
    dx = -longint'(p.x);
    dy = -longint'(p.y);
    radius = int_sqrt(longint'(dx * dx + dy * dy));
    c.arrived = 1'b0;
    c.linear_cmd = '0;
    c.angular_cmd = '0;
    if (radius < arrive_dist) begin
      c.arrived = 1'b1;
      return c;
    end
    alpha = bearing_q30(dx, dy) - longint'(p.heading) * 131072;
    for (int k = 0; k < 2; k++) begin
      if (alpha > PI_L) alpha = alpha - TWO_PI_L;
      else if (alpha < -PI_L) alpha = alpha + TWO_PI_L;
    end
    lim = longint'(ang_limit);
    if (alpha > PI_NINTH_L || alpha < -PI_NINTH_L) begin
      turn = (alpha > 0) ? lim : -lim;
    end else begin
      speed = (longint'(dist_gain) * radius + 2048) >> 12;
      if (speed > lin_limit) speed = lin_limit;
      c.linear_cmd = speed[14:0];
      turn = (longint'(head_gain) * alpha + (64'sd1 << 28)) >>> 29;
      if (turn > lim) turn = lim;
      if (turn < -lim) turn = -lim;
    end
    c.angular_cmd = turn[15:0];
    return c;
  endfunction

  // Record accepted poses and check command words at the rising edge.
  always @(posedge clk) begin
    cmd_word_t exp_cmd;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
    pose_taken <= rst_n && pose_ch.valid && pose_ch.ready;
    if (rst_n && pose_ch.valid && pose_ch.ready)
      expected_cmds.push_back(steer_to_origin('{pose_ch.pose_x, pose_ch.pose_y,
                                               pose_ch.pose_heading}));
    if (rst_n && cmd_ch.valid && cmd_ch.ready) begin
      if (expected_cmds.size() == 0) begin
        $error("command word with no pose pending");
        fail_count++;
      end else begin
        exp_cmd = expected_cmds.pop_front();
        if (cmd_ch.arrived !== exp_cmd.arrived) begin
          $error("arrived: expected %0d actual %0d", exp_cmd.arrived, cmd_ch.arrived);
          fail_count++;
        end
        if (cmd_ch.linear_cmd !== exp_cmd.linear_cmd) begin
          $error("linear_cmd: expected %0d actual %0d", exp_cmd.linear_cmd,
                 cmd_ch.linear_cmd);
          fail_count++;
        end
        if (cmd_ch.angular_cmd !== exp_cmd.angular_cmd) begin
          $error("angular_cmd: expected %0d actual %0d", exp_cmd.angular_cmd,
                 cmd_ch.angular_cmd);
          fail_count++;
        end
      end
    end
  end

  function automatic int pick_idle();
    int roll;
    roll = $urandom_range(99);
    if (no_idle || roll < 65) return 0;
    if (roll < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Pose driver: a word is held until taken, then the next one follows a gap.
  always @(negedge clk) begin
    if (!rst_n) begin
      pose_ch.valid <= 1'b0;
    end else if (!pose_ch.valid || pose_taken) begin
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
        pose_ch.valid <= 1'b0;
      end else if (pending_poses.size() != 0) begin
        pose_word_t p;
        p = pending_poses.pop_front();
        pose_ch.valid <= 1'b1;
        pose_ch.pose_x <= p.x;
        pose_ch.pose_y <= p.y;
        pose_ch.pose_heading <= p.heading;
        send_gap = pick_idle();
      end else begin
        pose_ch.valid <= 1'b0;
      end
    end
  end

  // Command sink with random stall stretches.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      cmd_ch.ready <= 1'b0;
    end else begin
      cmd_ch.ready <= 1'b1;
      stall_left = pick_idle();
    end
  end

  initial begin
    pose_ch.valid = 1'b0;
    pose_ch.pose_x = '0;
    pose_ch.pose_y = '0;
    pose_ch.pose_heading = '0;
    cmd_ch.ready = 1'b0;
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      CFG_ARRIVE_DIST: arrive_dist = value;
      CFG_DIST_GAIN:   dist_gain = value;
      CFG_HEAD_GAIN:   head_gain = value;
      CFG_LIN_LIMIT:   lin_limit = value[14:0];
      CFG_ANG_LIMIT:   ang_limit = value[14:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(logic [15:0] a, logic [15:0] dg, logic [15:0] hg,
                         logic [15:0] ll, logic [15:0] al);
    write_reg(CFG_ARRIVE_DIST, a);
    write_reg(CFG_DIST_GAIN, dg);
    write_reg(CFG_HEAD_GAIN, hg);
    write_reg(CFG_LIN_LIMIT, ll);
    write_reg(CFG_ANG_LIMIT, al);
  endtask

  task automatic add_pose(int x, int y, int h);
    pose_word_t p;
    p.x = x[15:0];
    p.y = y[15:0];
    p.heading = h[15:0];
    pending_poses.push_back(p);
  endtask

  // Random pose: mostly aimed near the origin bearing so the drive branch is hit.
  task automatic add_random_pose();
    int x, y, h, span;
    real aim;
    span = ($urandom_range(3) == 0) ? 32767 : $urandom_range(2000, 20);
    x = $urandom_range(2 * span) - span;
    y = $urandom_range(2 * span) - span;
    if ($urandom_range(3) == 0) begin
      x = $signed(16'($urandom));
      y = $signed(16'($urandom));
    end
    case ($urandom_range(9))
      0, 1, 2: h = $signed(16'($urandom));
      3:       h = $urandom_range(51472) - 25736;
      default: begin
        aim = $atan2(-real'(y), -real'(x)) * 8192.0;
        h = int'(aim) + $urandom_range(6000) - 3000;
        if (h > 32767) h = 32767;
        if (h < -32768) h = -32768;
      end
    endcase
    add_pose(x, y, h);
  endtask

  // Waits until every pose has been sent and every command word has come back.
  // The check runs at the rising edge, where the driver's last update has settled.
  task automatic drain();
    do @(posedge clk);
    while (pending_poses.size() != 0 || pose_ch.valid || expected_cmds.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed poses under reset settings: field extremes, arrival edge, turns.
    add_pose(0, 0, 0);
    add_pose(25, 0, 0);
    add_pose(26, 0, 25736);
    add_pose(-32768, -32768, -32768);
    add_pose(32767, 32767, 32767);
    add_pose(-32768, 0, 0);
    add_pose(32767, 0, 25736);
    add_pose(32767, 0, -25736);
    add_pose(0, -32768, 12868);
    add_pose(0, 32767, -12868);
    add_pose(-1000, 10, 0);
    add_pose(-1000, -10, 0);
    add_pose(1000, 0, 25000);
    add_pose(1000, 0, -25000);
    add_pose(-500, 0, 2000);
    add_pose(-500, 0, -2000);
    add_pose(-2560, 300, -600);
    add_pose(-5, 5, -32768);
    add_pose(-32768, 32767, -6434);
    add_pose(300, -32768, 21000);
    drain();

    // Spare register index must be ignored.
    write_reg(CFG_SPARE, 16'hFFFF);
    for (int i = 0; i < 250; i++) add_random_pose();
    drain();

    // Zero settings: origin bearing case and zero limits.
    set_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    add_pose(0, 0, 0);
    add_pose(0, 0, 32767);
    add_pose(0, 0, -32768);
    for (int i = 0; i < 150; i++) add_random_pose();
    drain();

    // Maximum settings: every pose arrives.
    set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_pose(-32768, -32768, 0);
    add_pose(32767, 32767, 0);
    for (int i = 0; i < 100; i++) add_random_pose();
    drain();

    // High gains with tiny arrival distance so the limits clamp.
    set_all(16'd1, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF);
    for (int i = 0; i < 150; i++) add_random_pose();
    drain();

    // Random settings, some phases with no idling at all.
    for (int ph = 0; ph < 8; ph++) begin
      no_idle = ($urandom_range(2) == 0);
      set_all(16'($urandom_range(600)), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom));
      for (int i = 0; i < 125; i++) add_random_pose();
      drain();
    end
    no_idle = 1'b0;

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/gtop_pkg.sv
rtl/gtop_if.sv
rtl/gtop_pipe.sv
rtl/go_to_origin_pose_controller_core.sv
sim/tb_go_to_origin_pose_controller_core.sv
